### sv/amc_pkg.sv
// Package for the affine matrix composer: constants, op codes, queue entry type
// and the CORDIC arctangent table. No dependencies.
`default_nettype none
package amc_pkg;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int ANG_FRAC         = 30;

    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_SCALE     = 2'd1;
    localparam logic [1:0] OP_ROTATE    = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    localparam logic signed [39:0] CORDIC_GAIN_Q30 = 40'sd652032874;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] arg_a;
        logic signed [31:0] arg_b;
    } amc_req_t;

    function automatic logic signed [39:0] atan_deg(input logic [4:0] idx);
        logic signed [39:0] v;
        unique case (idx)
            5'd0:  v = 40'sd48318382080;
            5'd1:  v = 40'sd28524006506;
            5'd2:  v = 40'sd15071301663;
            5'd3:  v = 40'sd7650428050;
            5'd4:  v = 40'sd3840059795;
            5'd5:  v = 40'sd1921901881;
            5'd6:  v = 40'sd961185452;
            5'd7:  v = 40'sd480622056;
            5'd8:  v = 40'sd240314695;
            5'd9:  v = 40'sd120157806;
            5'd10: v = 40'sd60078960;
            5'd11: v = 40'sd30039487;
            5'd12: v = 40'sd15019745;
            5'd13: v = 40'sd7509872;
            5'd14: v = 40'sd3754936;
            5'd15: v = 40'sd1877468;
            5'd16: v = 40'sd938734;
            5'd17: v = 40'sd469367;
            5'd18: v = 40'sd234684;
            5'd19: v = 40'sd117342;
            5'd20: v = 40'sd58671;
            5'd21: v = 40'sd29335;
            5'd22: v = 40'sd14668;
            5'd23: v = 40'sd7334;
            default: v = 40'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

### sv/affine_matrix_composer_unit.sv
// Top level of the affine matrix composer: front queue and back compute unit.
// Depends on amc_pkg, amc_front, amc_back.
//
//  channel | dir | tdata fields (low bit first)          | tuser
//  s_      | in  | func[1:0], arg_a[33:2], arg_b[65:34]    | -
//  m_      | out | m00..m22 (32 bits each, 288 bits)      | saturated
//
// A result for translate and scale takes 12 products through the one shared
// 32x32 multiplier, plus the last sum; rotate first runs angle reduction,
// folding and CORDIC, then the same multiply steps, and an unused code goes
// straight to the output. The back end takes the next request in the cycle
// after a result leaves. Reset loads identity.
// The front queue holds two requests while the back waits on m_tready.
`default_nettype none
module affine_matrix_composer_unit import amc_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // func, arg_a, arg_b, zero pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [287:0]      m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic              m_tuser    // saturated
);
    amc_req_t    in_req, q_req;
    logic        q_valid, q_ready;
    logic [31:0] m [9];

    assign in_req.func  = s_tdata[1:0];
    assign in_req.arg_a = s_tdata[33:2];
    assign in_req.arg_b = s_tdata[65:34];

    amc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    amc_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_m(m), .out_sat(m_tuser)
    );

    always_comb begin
        for (int k = 0; k < 9; k++) m_tdata[k*32 +: 32] = m[k];
    end

    logic unused_pad;
    assign unused_pad = ^s_tdata[71:66];
endmodule
`default_nettype wire

### sv/amc_front.sv
// Front end: takes input requests and holds them in a two-entry queue.
// Depends on amc_pkg.
`default_nettype none
module amc_front import amc_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire amc_req_t in_req,
    output logic          q_valid,
    input  wire logic     q_ready,
    output amc_req_t      q_req
);
    amc_req_t   ent_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = ent_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            // hold the request until the back end takes it
            ent_reg[wr_ptr_reg] <= in_req;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### sv/amc_back.sv
// Back end: CORDIC for cos/sin, one shared 32x32 multiplier, matrix registers
// and the output register. Depends on amc_pkg.
`default_nettype none
module amc_back import amc_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     q_valid,
    output logic          q_ready,
    input  wire amc_req_t q_req,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [31:0]   out_m [9],
    output logic          out_sat
);
    // smallest k with (360 << fb) << k >= 2^31, so one offset covers any negative angle
    function automatic int red_top(input int fb);
        int k;
        k = 0;
        while ((64'sd360 <<< (fb + k)) < 64'sd2147483648) k = k + 1;
        return k;
    endfunction

    function automatic logic [3:0] ent_idx(input logic [1:0] row, input logic [1:0] col);
        return {2'b00, row} * 4'd3 + {2'b00, col};
    endfunction

    localparam int STEPS   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int SH      = ANG_FRAC - FRAC_BITS;
    localparam int RED_TOP = red_top(FRAC_BITS);
    localparam logic signed [63:0] FULL    = 64'sd360 <<< FRAC_BITS;
    localparam logic signed [63:0] HALFT   = 64'sd180 <<< FRAC_BITS;
    localparam logic signed [63:0] QUARTER = 64'sd90 <<< FRAC_BITS;
    localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] RED_MOD = FULL <<< RED_TOP;
    localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic [1:0] ST_IDLE = 2'd0, ST_CORD = 2'd1, ST_MUL = 2'd2, ST_OUT = 2'd3;

    logic [1:0]         st_reg, st_next;
    amc_req_t           req_reg;
    logic signed [31:0] mat_reg [9];
    logic signed [31:0] res_reg [9];
    logic               sat_reg;
    logic [4:0]         it_reg;
    logic [4:0]         step_reg;
    logic signed [63:0] r_reg;
    logic signed [63:0] mod_reg;
    logic [4:0]         red_cnt_reg;
    logic               flip_reg;
    logic [1:0]         red_reg;
    logic signed [39:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] c_reg, s_reg;
    logic signed [63:0] acc_reg, prod_reg;
    logic               pvalid_reg;
    logic [3:0]         pidx_reg;

    logic [1:0]         mrow, mterm;
    logic signed [31:0] m0, m1;
    logic signed [31:0] opa, opb;
    logic signed [63:0] mprod;
    logic signed [63:0] red_one, red_two;
    logic signed [63:0] r_wrap, r_fold;
    logic               fold;
    logic signed [39:0] dx, dy;
    logic signed [39:0] ct, st;
    logic signed [31:0] c_fin, s_fin;
    logic [1:0]         pr, pt;
    logic               close;
    logic [3:0]         widx;
    logic signed [65:0] sum2, rsum;
    logic signed [31:0] satv;
    logic               clip;

    assign q_ready   = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_sat   = sat_reg;
    always_comb begin
        for (int k = 0; k < 9; k++) out_m[k] = res_reg[k];
    end

    // step_reg 0..11: row step[3:2], four product slots per row in step[1:0]
    assign mrow  = (step_reg[3:2] == 2'd3) ? 2'd0 : step_reg[3:2];
    assign mterm = step_reg[1:0];
    assign m0    = mat_reg[ent_idx(mrow, 2'd0)];
    assign m1    = mat_reg[ent_idx(mrow, 2'd1)];

    always_comb begin
        opa = 32'sd0;
        opb = 32'sd0;
        unique case (req_reg.func)
            OP_TRANSLATE: begin
                opa = mterm[0] ? m1 : m0;
                opb = mterm[0] ? req_reg.arg_b : req_reg.arg_a;
            end
            OP_SCALE: begin
                opa = mterm[0] ? m1 : m0;
                opb = mterm[0] ? req_reg.arg_b : req_reg.arg_a;
            end
            OP_ROTATE: begin
                // col0: c*m0 + s*m1 ; col1: c*m1 - s*m0
                unique case (mterm)
                    2'd0: begin opa = m0; opb = c_reg; end
                    2'd1: begin opa = m1; opb = s_reg; end
                    2'd2: begin opa = m1; opb = c_reg; end
                    default: begin opa = m0; opb = s_reg; end
                endcase
            end
            default: ;
        endcase
    end

    assign mprod = opa * opb;

    // angle reduction: two compare-and-subtract stages per cycle
    always_comb begin
        red_one = (r_reg >= mod_reg) ? r_reg - mod_reg : r_reg;
        red_two = (red_one >= (mod_reg >>> 1)) ? red_one - (mod_reg >>> 1) : red_one;
    end

    // wrap to [-180, 180), then fold into [-90, 90] and remember the sign flip
    always_comb begin
        r_wrap = (r_reg >= HALFT) ? r_reg - FULL : r_reg;
        r_fold = r_wrap;
        fold   = 1'b0;
        if (r_wrap > QUARTER) begin
            r_fold = r_wrap - HALFT;
            fold   = 1'b1;
        end else if (r_wrap < -QUARTER) begin
            r_fold = r_wrap + HALFT;
            fold   = 1'b1;
        end
    end

    assign dx = cy_reg >>> it_reg;
    assign dy = cx_reg >>> it_reg;
    assign ct = cx_reg + (40'sd1 <<< (SH - 1));
    assign st = cy_reg + (40'sd1 <<< (SH - 1));
    assign c_fin = flip_reg ? -32'(ct >>> SH) : 32'(ct >>> SH);
    assign s_fin = flip_reg ? -32'(st >>> SH) : 32'(st >>> SH);

    // product index -> target entry, exact sum, rounding and saturation
    always_comb begin
        pr    = pidx_reg[3:2];
        pt    = pidx_reg[1:0];
        close = (req_reg.func == OP_SCALE) || pt[0];
        if (req_reg.func == OP_TRANSLATE) widx = ent_idx(pr, 2'd2);
        else if (req_reg.func == OP_SCALE) widx = ent_idx(pr, {1'b0, pt[0]});
        else widx = ent_idx(pr, {1'b0, pt[1]});
        if (req_reg.func == OP_SCALE) sum2 = 66'(prod_reg);
        else if (req_reg.func == OP_ROTATE && pt[1]) sum2 = 66'(acc_reg) - 66'(prod_reg);
        else sum2 = 66'(acc_reg) + 66'(prod_reg);
        rsum = (sum2 + HALF_LSB) >>> FRAC_BITS;
        if (req_reg.func == OP_TRANSLATE)
            rsum = rsum + 66'(mat_reg[ent_idx(pr, 2'd2)]);
        clip = (rsum > 66'sd2147483647) || (rsum < -66'sd2147483648);
        if (rsum > 66'sd2147483647) satv = 32'sh7fffffff;
        else if (rsum < -66'sd2147483648) satv = 32'sh80000000;
        else satv = rsum[31:0];
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (q_valid) st_next = (q_req.func == OP_ROTATE) ? ST_CORD :
                                            (q_req.func == OP_NONE) ? ST_OUT : ST_MUL;
            ST_CORD: if (red_reg == 2'd3 && it_reg == 5'(STEPS)) st_next = ST_MUL;
            ST_MUL:  if (pvalid_reg && pidx_reg == 4'd11) st_next = ST_OUT;
            default: if (out_ready) st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            for (int k = 0; k < 9; k++)
                mat_reg[k] <= (k == 0 || k == 4 || k == 8) ? ONE[31:0] : 32'sd0;
            pvalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            unique case (st_reg)
                ST_IDLE: begin
                    req_reg     <= q_req;
                    sat_reg     <= 1'b0;
                    step_reg    <= 5'd0;
                    pvalid_reg  <= 1'b0;
                    red_reg     <= 2'd0;
                    it_reg      <= 5'd0;
                    // offset a negative angle by a multiple of 360 degrees
                    r_reg       <= q_req.arg_a[31] ? 64'($signed(q_req.arg_a)) + RED_MOD :
                                                     64'($signed(q_req.arg_a));
                    mod_reg     <= RED_MOD;
                    red_cnt_reg <= 5'(RED_TOP + 1);
                    flip_reg    <= 1'b0;
                    for (int k = 0; k < 9; k++) res_reg[k] <= mat_reg[k];
                end
                ST_CORD: begin
                    unique case (red_reg)
                        2'd0: begin
                            if (red_cnt_reg == 5'd1) begin
                                r_reg       <= red_one;
                                red_cnt_reg <= 5'd0;
                                red_reg     <= 2'd1;
                            end else begin
                                r_reg       <= red_two;
                                mod_reg     <= mod_reg >>> 2;
                                red_cnt_reg <= red_cnt_reg - 5'd2;
                                if (red_cnt_reg == 5'd2) red_reg <= 2'd1;
                            end
                        end
                        2'd1: begin
                            flip_reg <= fold;
                            cz_reg   <= 40'(r_fold) <<< SH;
                            cx_reg   <= CORDIC_GAIN_Q30;
                            cy_reg   <= 40'sd0;
                            red_reg  <= 2'd3;
                        end
                        default: begin
                            if (it_reg != 5'(STEPS)) begin
                                if (!cz_reg[39]) begin
                                    cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy;
                                    cz_reg <= cz_reg - atan_deg(it_reg);
                                end else begin
                                    cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy;
                                    cz_reg <= cz_reg + atan_deg(it_reg);
                                end
                                it_reg <= it_reg + 5'd1;
                            end else begin
                                c_reg <= c_fin;
                                s_reg <= s_fin;
                            end
                        end
                    endcase
                end
                ST_MUL: begin
                    // issue products 0..11; accumulate pairs in the cycle after
                    if (step_reg != 5'd12) begin
                        prod_reg   <= mprod;
                        pidx_reg   <= step_reg[3:0];
                        pvalid_reg <= 1'b1;
                        step_reg   <= step_reg + 5'd1;
                    end else begin
                        pvalid_reg <= 1'b0;
                    end
                    if (pvalid_reg) begin
                        if (!close) begin
                            acc_reg <= prod_reg;
                        end else begin
                            res_reg[widx] <= satv;
                            if (clip) sat_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                    if (out_ready) begin
                        for (int k = 0; k < 9; k++) mat_reg[k] <= res_reg[k];
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### tb/sv/affine_matrix_composer_unit_test.sv
// Testbench for affine_matrix_composer_unit: streams translate, scale, rotate and
// unused requests, predicts the composed matrix, checks every result in order.
// Depends on amc_pkg and the affine_matrix_composer_unit RTL.
`timescale 1ns / 1ps
module affine_matrix_composer_unit_test;
    import amc_pkg::*;

    localparam int FRAC = 16;
    localparam int STEPS = 16;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] entry [9];
        logic               clipped;
    } matrix_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic         m_tuser;

    affine_matrix_composer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    amc_req_t    pending_reqs [$];
    matrix_out_t expected_mats [$];
    logic signed [31:0] xform [9];
    int errors = 0;
    int results_seen = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int sat_count = 0;

    // atan(2^-i) in degrees, 30 fraction bits
    localparam longint ATAN_DEG [24] = '{
        64'sd48318382080, 64'sd28524006506, 64'sd15071301663, 64'sd7650428050,
        64'sd3840059795, 1921901881, 961185452, 480622056,
        240314695, 120157806, 60078960, 30039487,
        15019745, 7509872, 3754936, 1877468,
        938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334
    };

    function automatic logic signed [65:0] round_pair(input logic signed [65:0] p0,
                                                      input logic signed [65:0] p1);
        return (p0 + p1 + (66'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v,
                                                  inout logic hit);
        if (v > 66'sd2147483647) begin
            hit = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -66'sd2147483648) begin
            hit = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    task automatic rotation_cos_sin(input longint ang, output longint c, output longint s);
        longint full, half, quarter, r, x, y, z, t, dx, dy;
        bit flip;
        full = longint'(360) << FRAC;
        half = longint'(180) << FRAC;
        quarter = longint'(90) << FRAC;
        flip = 0;
        r = ang % full;
        if (r < 0) r += full;
        if (r >= half) r -= full;
        if (r > quarter) begin
            r -= half;
            flip = 1;
        end else if (r < -quarter) begin
            r += half;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = r << (30 - FRAC);
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                t = x - dx; y = y + dy; x = t; z -= ATAN_DEG[i];
            end else begin
                t = x + dx; y = y - dy; x = t; z += ATAN_DEG[i];
            end
        end
        t = longint'(1) << (30 - FRAC - 1);
        c = (x + t) >>> (30 - FRAC);
        s = (y + t) >>> (30 - FRAC);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endtask

    // Apply one elementary transform to the held matrix and return the new one.
    task automatic compose_step(input amc_req_t req, output matrix_out_t res);
        logic signed [65:0] a, b, m0, m1, m2, cs, sn;
        longint c, s;
        logic hit;
        a = req.arg_a;
        b = req.arg_b;
        hit = 1'b0;
        if (req.func == OP_ROTATE) begin
            rotation_cos_sin(longint'(req.arg_a), c, s);
            cs = c;
            sn = s;
        end
        for (int r = 0; r < 3; r++) begin
            m0 = xform[r*3];
            m1 = xform[r*3+1];
            m2 = xform[r*3+2];
            case (req.func)
                OP_TRANSLATE: xform[r*3+2] = clip32(m2 + round_pair(m0 * a, m1 * b), hit);
                OP_SCALE: begin
                    xform[r*3]   = clip32(round_pair(m0 * a, 66'sd0), hit);
                    xform[r*3+1] = clip32(round_pair(m1 * b, 66'sd0), hit);
                end
                OP_ROTATE: begin
                    xform[r*3]   = clip32(round_pair(cs * m0, sn * m1), hit);
                    xform[r*3+1] = clip32(round_pair(cs * m1, -(sn * m0)), hit);
                end
                default: ;
            endcase
        end
        res.entry = xform;
        res.clipped = hit;
    endtask

    function automatic amc_req_t mk(input logic [1:0] f, input logic [31:0] a,
                                    input logic [31:0] b);
        amc_req_t q;
        q.func = f;
        q.arg_a = a;
        q.arg_b = b;
        return q;
    endfunction

    // Sender: bursts of requests separated by random gaps.
    int gap_left = 0;
    int burst_left = 4;
    always @(posedge aclk) begin
        matrix_out_t res;
        amc_req_t nxt;
        logic drive_valid;
        if (aresetn) begin
            drive_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                compose_step(pending_reqs[0], res);
                op_count[pending_reqs[0].func]++;
                if (res.clipped) sat_count++;
                expected_mats.push_back(res);
                void'(pending_reqs.pop_front());
                drive_valid = 1'b0;
            end
            if (!drive_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    drive_valid = 1'b1;
                    nxt = pending_reqs[0];
                    s_tdata <= {6'b0, nxt.arg_b, nxt.arg_a, nxt.func};
                    if (--burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
            s_tvalid <= drive_valid;
        end
    end

    // Receiver: stall on a rotating pattern, reloaded now and then.
    logic [15:0] stall_pattern = 16'hffff;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ($urandom_range(0, 63) == 0) begin
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
            end
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            m_tready <= stall_pattern[0];
        end
    end

    // Result checker
    always @(posedge aclk) begin
        matrix_out_t want;
        logic bad;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_mats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result with no request pending");
            end else begin
                want = expected_mats.pop_front();
                bad = 1'b0;
                for (int k = 0; k < 9; k++) begin
                    if (m_tdata[k*32 +: 32] !== want.entry[k]) begin
                        bad = 1'b1;
                        if (errors < 10)
                            $display("ERROR: result %0d m%0d%0d expected %h got %h",
                                     results_seen, k / 3, k % 3, want.entry[k],
                                     m_tdata[k*32 +: 32]);
                    end
                end
                if (m_tuser !== want.clipped) begin
                    bad = 1'b1;
                    if (errors < 10)
                        $display("ERROR: result %0d saturated expected %b got %b",
                                 results_seen, want.clipped, m_tuser);
                end
                if (bad) errors++;
            end
        end
    end

    // Watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_arg(input logic [1:0] f);
        logic [31:0] mag;
        if ($urandom_range(0, 19) == 0) return $urandom;
        case (f)
            OP_SCALE: begin
                mag = $urandom_range(32'h0000_c000, 32'h0001_5000);
                return ($urandom_range(0, 3) == 0) ? -mag : mag;
            end
            OP_ROTATE: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    initial begin
        logic [1:0] f;
        // directed: extremes, each op, angle folding, saturation and recovery
        pending_reqs.push_back(mk(OP_NONE, 32'hffffffff, 32'hffffffff));
        pending_reqs.push_back(mk(OP_TRANSLATE, 32'h7fffffff, 32'h80000000));
        pending_reqs.push_back(mk(OP_TRANSLATE, 32'h80000000, 32'h7fffffff));
        pending_reqs.push_back(mk(OP_TRANSLATE, 32'h7fffffff, 32'h7fffffff));
        pending_reqs.push_back(mk(OP_TRANSLATE, 32'h80000000, 32'h80000000));
        pending_reqs.push_back(mk(OP_ROTATE, 32'd0, 32'hffffffff));
        pending_reqs.push_back(mk(OP_ROTATE, 32'd90 << 16, 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, -(32'd90 << 16), 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, 32'd180 << 16, 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, -(32'd180 << 16), 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, 32'd360 << 16, 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, 32'd135 << 16, 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, 32'h7fffffff, 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, 32'h80000000, 32'd0));
        pending_reqs.push_back(mk(OP_SCALE, 32'h7fffffff, 32'h80000000));
        pending_reqs.push_back(mk(OP_SCALE, 32'h7fffffff, 32'h7fffffff));
        pending_reqs.push_back(mk(OP_SCALE, 32'd1, 32'hffffffff));
        pending_reqs.push_back(mk(OP_SCALE, 32'h00008000, 32'hffff8000));
        pending_reqs.push_back(mk(OP_ROTATE, 32'd30 << 16, 32'd0));
        pending_reqs.push_back(mk(OP_NONE, 32'h12345678, 32'h9abcdef0));
        // random: mostly near-unity scales and moderate angles keep the matrix alive
        repeat (1430) begin
            f = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
            pending_reqs.push_back(mk(f, rand_arg(f), (f == OP_SCALE) ? rand_arg(f) : $urandom));
        end
        // zero scale near the end, since it clears the linear part for good
        pending_reqs.push_back(mk(OP_SCALE, 32'd0, 32'd0));
        pending_reqs.push_back(mk(OP_ROTATE, 32'd45 << 16, 32'd0));
        pending_reqs.push_back(mk(OP_TRANSLATE, 32'h7fffffff, 32'h80000000));

        xform = '{32'sd65536, 0, 0, 0, 32'sd65536, 0, 0, 0, 32'sd65536};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() > 0 || expected_mats.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (expected_mats.size() > 0) errors++;
        $display("Covered %0d translate, %0d scale, %0d rotate, %0d unused requests;",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d results checked, %0d with saturation, %0d failing.",
                 results_seen, sat_count, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
